[rtl/pcbp_pkg.sv]
// Shared types and constants for the piecewise cubic Bezier path block.
// Used by the front, queue, back and top-level files; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pcbp_pkg;

    // Path geometry
    localparam int SEGMENTS   = 4;
    localparam int NUM_POINTS = 3 * SEGMENTS + 1;
    localparam int SEG_WRAP   = 3 * SEGMENTS;
    localparam int PT_AW      = $clog2(NUM_POINTS);
    localparam int SEG_W      = 4;

    // Number formats
    localparam int COORD_BITS      = 16;
    localparam int PARAM_FRAC_BITS = 16;
    localparam int STEP_W          = 17;
    localparam int POINT_W         = 3 * COORD_BITS;

    // Widths of the weight and sum datapath
    localparam int WGT_W  = PARAM_FRAC_BITS + 1;
    localparam int PROD_W = 2 * WGT_W;
    localparam int TERM_W = WGT_W + 1 + COORD_BITS;
    localparam int ACC_W  = TERM_W + 2;

    localparam logic [WGT_W-1:0]  PARAM_ONE  = WGT_W'(64'd1 << PARAM_FRAC_BITS);
    localparam logic [PROD_W-1:0] PROD_HALF  = PROD_W'(64'd1 << (PARAM_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] ACC_HALF =
        ACC_W'(64'd1 << (PARAM_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] ACC_CMAX =
        ACC_W'((64'd1 << (COORD_BITS - 1)) - 64'd1);
    localparam logic signed [ACC_W-1:0] ACC_CMIN = -ACC_CMAX - ACC_W'(1);

    // alpha_step reset: 0.02 rounded to nearest
    localparam logic [STEP_W-1:0] ALPHA_STEP_RESET =
        STEP_W'(((64'd1 << PARAM_FRAC_BITS) * 64'd2 + 64'd50) / 64'd100);

    // Input action codes, reused as command kinds
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic                       kind;
        logic [PT_AW-1:0]           index;
        logic [PARAM_FRAC_BITS-1:0] param;
        logic [SEG_W-1:0]           seg;
        logic [POINT_W-1:0]         point;   // {z, y, x}
    } t_cmd;

endpackage
`default_nettype wire

[rtl/pcbp_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pcbp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 13
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/pcbp_front.sv]
// Front end: takes input beats and the alpha_step register, drops loads to
// absent slots, advances curve parameter and segment per tick. Uses pcbp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcbp_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_valid,
    input  wire logic [pcbp_pkg::STEP_W-1:0]    i_cfg_data,
    // input item
    input  wire logic                           i_valid,
    input  wire logic                           i_action,
    input  wire logic [3:0]                     i_point_index,
    input  wire logic [pcbp_pkg::POINT_W-1:0]   i_point,
    output logic                                o_ready,
    // queue push side
    input  wire logic                           i_q_full,
    output logic                                o_push,
    output pcbp_pkg::t_cmd                      o_cmd
);

    logic [pcbp_pkg::STEP_W-1:0]          r_alpha;
    logic [pcbp_pkg::PARAM_FRAC_BITS-1:0] r_param;
    logic [pcbp_pkg::SEG_W-1:0]           r_seg;

    logic                                 accept;
    logic                                 tick;
    logic                                 in_range;
    logic [pcbp_pkg::STEP_W:0]            param_sum;
    logic [pcbp_pkg::SEG_W:0]             seg_sum;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign tick     = (i_action == pcbp_pkg::ACT_TICK);
    assign in_range = ({1'b0, i_point_index} < 5'(pcbp_pkg::NUM_POINTS));

    // ticks always go on; loads only when the slot exists
    assign o_push = accept && (tick || in_range);

    always_comb begin
        o_cmd.kind  = i_action;
        o_cmd.index = i_point_index[pcbp_pkg::PT_AW-1:0];
        o_cmd.param = r_param;
        o_cmd.seg   = r_seg;
        o_cmd.point = i_point;
    end

    // next parameter and segment start
    assign param_sum = {2'b00, r_param} + {1'b0, r_alpha};
    assign seg_sum   = {1'b0, r_seg} + (pcbp_pkg::SEG_W + 1)'(3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= pcbp_pkg::ALPHA_STEP_RESET;
            r_param <= '0;
            r_seg   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_alpha <= i_cfg_data;
            end
            if (accept && tick) begin
                if (param_sum >= (pcbp_pkg::STEP_W + 1)'(pcbp_pkg::PARAM_ONE)) begin
                    r_param <= '0;
                    if (seg_sum >= (pcbp_pkg::SEG_W + 1)'(pcbp_pkg::SEG_WRAP)) begin
                        r_seg <= pcbp_pkg::SEG_W'(seg_sum
                                 - (pcbp_pkg::SEG_W + 1)'(pcbp_pkg::SEG_WRAP));
                    end else begin
                        r_seg <= seg_sum[pcbp_pkg::SEG_W-1:0];
                    end
                end else begin
                    r_param <= param_sum[pcbp_pkg::PARAM_FRAC_BITS-1:0];
                end
            end
        end
    end

endmodule
`default_nettype wire

[rtl/pcbp_queue.sv]
// Short command queue between front and back, built from flip-flops.
// Uses pcbp_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none
module pcbp_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire pcbp_pkg::t_cmd  i_cmd,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output pcbp_pkg::t_cmd       o_cmd
);

    localparam int QAW = $clog2(pcbp_pkg::QUEUE_DEPTH);
    localparam int QCW = $clog2(pcbp_pkg::QUEUE_DEPTH + 1);

    pcbp_pkg::t_cmd r_mem [pcbp_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == QCW'(pcbp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QAW'(pcbp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + QAW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == QAW'(pcbp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + QAW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

endmodule
`default_nettype wire

[rtl/pcbp_back.sv]
// Back end: writes loaded points to the point RAM and evaluates ticks with one
// shared weight multiplier and three coordinate multipliers. Uses pcbp_pkg, pcbp_ram.
`timescale 1ns / 1ps
`default_nettype none
module pcbp_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // queue pop side
    input  wire logic                              i_q_valid,
    input  wire pcbp_pkg::t_cmd                    i_q_cmd,
    output logic                                   o_pop,
    // result
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [pcbp_pkg::COORD_BITS-1:0]        o_pos_x,
    output logic [pcbp_pkg::COORD_BITS-1:0]        o_pos_y,
    output logic [pcbp_pkg::COORD_BITS-1:0]        o_pos_z,
    output logic [pcbp_pkg::SEG_W-1:0]             o_seg
);

    localparam int CW = pcbp_pkg::COORD_BITS;
    localparam int F  = pcbp_pkg::PARAM_FRAC_BITS;

    // sequencer
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // step numbers inside ST_RUN
    localparam logic [3:0] STEP_BB   = 4'd1;
    localparam logic [3:0] STEP_AA   = 4'd2;
    localparam logic [3:0] STEP_W0   = 4'd3;
    localparam logic [3:0] STEP_W1   = 4'd4;
    localparam logic [3:0] STEP_W2   = 4'd5;
    localparam logic [3:0] STEP_W3   = 4'd6;
    localparam logic [3:0] STEP_RD0  = 4'd6;
    localparam logic [3:0] STEP_MUL0 = 4'd7;
    localparam logic [3:0] STEP_MUL3 = 4'd10;
    localparam logic [3:0] STEP_ACC0 = 4'd8;
    localparam logic [3:0] STEP_LAST = 4'd11;

    logic [1:0]                  r_state;
    logic [3:0]                  r_step;
    logic [F-1:0]                r_a;
    logic [pcbp_pkg::SEG_W-1:0]  r_segb;

    logic [pcbp_pkg::WGT_W-1:0]  r_bb;
    logic [pcbp_pkg::WGT_W-1:0]  r_aa;
    logic [pcbp_pkg::WGT_W-1:0]  r_w [4];
    logic [pcbp_pkg::PROD_W-1:0] r_prod;
    logic signed [pcbp_pkg::TERM_W-1:0] r_term [3];
    logic signed [pcbp_pkg::ACC_W-1:0]  r_acc  [3];

    logic [pcbp_pkg::WGT_W-1:0]  a_ext;
    logic [pcbp_pkg::WGT_W-1:0]  b_ext;
    logic [pcbp_pkg::WGT_W-1:0]  mul_l;
    logic [pcbp_pkg::WGT_W-1:0]  mul_r;
    logic [pcbp_pkg::PROD_W-1:0] prod_rnd_sum;
    logic [pcbp_pkg::WGT_W-1:0]  prod_rnd;
    logic [pcbp_pkg::WGT_W+1:0]  prod_rnd3;
    logic [3:0]                  rd_ofs;
    logic [3:0]                  mul_ofs;
    logic [pcbp_pkg::WGT_W-1:0]  w_sel;
    logic [pcbp_pkg::PT_AW-1:0]  raddr;
    logic [pcbp_pkg::POINT_W-1:0] rdata;
    logic                        ram_we;
    logic                        out_free;

    function automatic logic [CW-1:0] f_scale(input logic signed [pcbp_pkg::ACC_W-1:0] s);
        logic signed [pcbp_pkg::ACC_W-1:0] t;
        logic signed [pcbp_pkg::ACC_W-1:0] r;
        t = s + pcbp_pkg::ACC_HALF;
        r = t >>> F;
        if (r > pcbp_pkg::ACC_CMAX) begin
            r = pcbp_pkg::ACC_CMAX;
        end else if (r < pcbp_pkg::ACC_CMIN) begin
            r = pcbp_pkg::ACC_CMIN;
        end
        return r[CW-1:0];
    endfunction

    assign out_free = !o_valid || i_ready;
    assign o_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign ram_we   = o_pop && (i_q_cmd.kind == pcbp_pkg::ACT_LOAD);

    // point memory: loads write from the queue head, ticks read one point a step
    assign rd_ofs = r_step - STEP_RD0;
    assign raddr  = pcbp_pkg::PT_AW'(r_segb) + pcbp_pkg::PT_AW'(rd_ofs[1:0]);

    pcbp_ram #(
        .WIDTH (pcbp_pkg::POINT_W),
        .DEPTH (pcbp_pkg::NUM_POINTS)
    ) u_points (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_q_cmd.index),
        .i_wdata (i_q_cmd.point),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // shared weight multiplier operands
    assign a_ext = {1'b0, r_a};
    assign b_ext = pcbp_pkg::PARAM_ONE - a_ext;

    always_comb begin
        case (r_step)
            4'd0:    begin mul_l = b_ext; mul_r = b_ext; end
            STEP_BB: begin mul_l = a_ext; mul_r = a_ext; end
            STEP_AA: begin mul_l = r_bb;  mul_r = b_ext; end
            STEP_W0: begin mul_l = r_bb;  mul_r = a_ext; end
            STEP_W1: begin mul_l = r_aa;  mul_r = b_ext; end
            STEP_W2: begin mul_l = r_aa;  mul_r = a_ext; end
            default: begin mul_l = '0;    mul_r = '0;    end
        endcase
    end

    // round the previous product back to Q1.F
    assign prod_rnd_sum = r_prod + pcbp_pkg::PROD_HALF;
    assign prod_rnd     = prod_rnd_sum[F+pcbp_pkg::WGT_W-1:F];
    assign prod_rnd3    = {1'b0, prod_rnd, 1'b0} + {2'b00, prod_rnd};

    // weight for the current multiply-accumulate step
    assign mul_ofs = r_step - STEP_MUL0;
    assign w_sel   = r_w[mul_ofs[1:0]];

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a    <= i_q_cmd.param;
            r_segb <= i_q_cmd.seg;
        end
        if (r_state == ST_RUN) begin
            r_prod <= mul_l * mul_r;
            case (r_step)
                STEP_BB: r_bb   <= prod_rnd;
                STEP_AA: r_aa   <= prod_rnd;
                STEP_W0: r_w[0] <= prod_rnd;
                STEP_W1: r_w[1] <= prod_rnd3[pcbp_pkg::WGT_W-1:0];
                STEP_W2: r_w[2] <= prod_rnd3[pcbp_pkg::WGT_W-1:0];
                STEP_W3: r_w[3] <= prod_rnd;
                default: ;
            endcase
            for (int c = 0; c < 3; c++) begin
                if (r_step >= STEP_MUL0 && r_step <= STEP_MUL3) begin
                    r_term[c] <= $signed({1'b0, w_sel}) * $signed(rdata[c*CW +: CW]);
                end
                if (r_step == STEP_ACC0) begin
                    r_acc[c] <= pcbp_pkg::ACC_W'(r_term[c]);
                end else if (r_step > STEP_ACC0) begin
                    r_acc[c] <= r_acc[c] + pcbp_pkg::ACC_W'(r_term[c]);
                end
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_step <= '0;
                    if (o_pop && (i_q_cmd.kind == pcbp_pkg::ACT_TICK)) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (r_step == STEP_LAST) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if ((r_state == ST_EMIT) && out_free) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && out_free) begin
            o_pos_x <= f_scale(r_acc[0]);
            o_pos_y <= f_scale(r_acc[1]);
            o_pos_z <= f_scale(r_acc[2]);
            o_seg   <= r_segb;
        end
    end

endmodule
`default_nettype wire

[rtl/piecewise_cubic_bezier_path_top.sv]
// Path: a tick goes through the queue, the back's run steps and emit state and the output
// register to o_m_tvalid; a load is written to the point RAM from the queue head, no result.
// Throughput: one load per cycle while the back is idle; a tick keeps the back busy, as it
// shares one weight multiplier (six products) and the RAM's single read port (four reads).
// Reset: synchronous, active low; clears curve parameter, segment start, queue and result
// valid, and sets alpha_step to 1311. Control points are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module piecewise_cubic_bezier_path_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: alpha_step
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [16:0] i_cfg_data,
    // input items
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [55:0] i_s_tdata,   // point_index[3:0], point_x[19:4],
                                          // point_y[35:20], point_z[51:36], zero pad
    input  wire logic [0:0]  i_s_tuser,   // action[0]
    // results
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [55:0]      o_m_tdata    // pos_x[15:0], pos_y[31:16], pos_z[47:32],
                                          // segment_start[51:48], zero pad
);

    localparam int CW = pcbp_pkg::COORD_BITS;

    pcbp_pkg::t_cmd push_cmd;
    pcbp_pkg::t_cmd head_cmd;
    logic           push;
    logic           q_full;
    logic           q_valid;
    logic           pop;
    logic [CW-1:0]  pos_x;
    logic [CW-1:0]  pos_y;
    logic [CW-1:0]  pos_z;
    logic [pcbp_pkg::SEG_W-1:0] seg;

    assign o_cfg_ready = 1'b1;

    pcbp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_s_tvalid),
        .i_action      (i_s_tuser[0]),
        .i_point_index (i_s_tdata[3:0]),
        .i_point       ({i_s_tdata[51:36], i_s_tdata[35:20], i_s_tdata[19:4]}),
        .o_ready       (o_s_tready),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    pcbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    pcbp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (head_cmd),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_pos_x   (pos_x),
        .o_pos_y   (pos_y),
        .o_pos_z   (pos_z),
        .o_seg     (seg)
    );

    assign o_m_tdata = {4'b0000, seg, pos_z, pos_y, pos_x};

endmodule
`default_nettype wire
